// ===== design/tlri_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlri_pkg
// Shared types, constants and helpers for the text line row indexer.
// ----------------------------------------------------------------------------
package tlri_pkg;

  // default sizes of the block
  localparam int OffsetBitsDefault      = 32;
  localparam int FrameBitsDefault       = 24;
  localparam int MaxCommentCharsDefault = 8;

  // configuration register widths
  localparam int CfgDataW      = 64;
  localparam int CommentCountW = 4;
  localparam int HeaderW       = 16;
  localparam int CfgIdxW       = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegCommentChars = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCommentCount = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHeaderLines  = 2'd2;

  // reset values of the configuration registers ("#/c!;")
  localparam logic [CfgDataW-1:0]      CommentCharsReset = 64'h0000_003B_2163_2F23;
  localparam logic [CommentCountW-1:0] CommentCountReset = 4'd5;
  localparam logic [HeaderW-1:0]       HeaderLinesReset  = 16'd0;

  // line end bytes
  localparam logic [7:0] LfByte = 8'h0A;
  localparam logic [7:0] CrByte = 8'h0D;

  // configuration as seen by the scanner
  typedef struct packed {
    logic [CfgDataW-1:0]      comment_chars;
    logic [CommentCountW-1:0] comment_count;
  } cfg_t;

  // header counter load request
  typedef struct packed {
    logic               load;
    logic [HeaderW-1:0] value;
  } hdr_load_t;

  // tab, line feed, vertical tab, form feed, carriage return and space
  function automatic logic is_white(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

endpackage

// ===== design/tlri_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlri_cfg_regs
// Configuration registers and header counter load request.
// ----------------------------------------------------------------------------
module tlri_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tlri_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [tlri_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output tlri_pkg::cfg_t                   cfg_o,
  output tlri_pkg::hdr_load_t              hdr_load_o
);

  logic [tlri_pkg::CfgDataW-1:0]      comment_chars_q, comment_chars_d;
  logic [tlri_pkg::CommentCountW-1:0] comment_count_q, comment_count_d;

  // register write decode
  always_comb begin
    comment_chars_d  = comment_chars_q;
    comment_count_d  = comment_count_q;
    hdr_load_o.load  = 1'b0;
    hdr_load_o.value = cfg_wdata_i[tlri_pkg::HeaderW-1:0];
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tlri_pkg::RegCommentChars: comment_chars_d = cfg_wdata_i;
        tlri_pkg::RegCommentCount:
          comment_count_d = cfg_wdata_i[tlri_pkg::CommentCountW-1:0];
        tlri_pkg::RegHeaderLines: hdr_load_o.load = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comment_chars_q <= tlri_pkg::CommentCharsReset;
      comment_count_q <= tlri_pkg::CommentCountReset;
    end else begin
      comment_chars_q <= comment_chars_d;
      comment_count_q <= comment_count_d;
    end
  end

  assign cfg_o.comment_chars = comment_chars_q;
  assign cfg_o.comment_count = comment_count_q;

`ifndef SYNTHESIS
  a_chars_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_idx_i == tlri_pkg::RegCommentChars) |=> comment_chars_q == $past(cfg_wdata_i))
    else $error("comment chars write lost");
  a_chars_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cfg_we_i && cfg_idx_i == tlri_pkg::RegCommentChars) |=> $stable(comment_chars_q))
    else $error("comment chars changed without a write");
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cfg_we_i && cfg_idx_i == tlri_pkg::RegCommentCount) |=> $stable(comment_count_q))
    else $error("comment count changed without a write");
`endif

endmodule

// ===== design/tlri_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlri_scan
// Line scanner state: byte offset, row slot, comment and data flags, header
// counter. Classifies the staged byte and forms the line end result.
// ----------------------------------------------------------------------------
module tlri_scan #(
  parameter int OFFSET_BITS       = tlri_pkg::OffsetBitsDefault,
  parameter int FRAME_BITS        = tlri_pkg::FrameBitsDefault,
  parameter int MAX_COMMENT_CHARS = tlri_pkg::MaxCommentCharsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tlri_pkg::cfg_t         cfg_i,
  input  tlri_pkg::hdr_load_t    hdr_load_i,
  input  logic                   step_i,
  input  logic [7:0]             byte_i,
  output logic                   res_valid_o,
  output logic [FRAME_BITS-1:0]  res_slot_o,
  output logic [OFFSET_BITS-1:0] res_offset_o,
  output logic                   res_data_o,
  output logic                   res_header_o
);

  logic [OFFSET_BITS-1:0]       offset_q, offset_d, offset_nxt;
  logic [FRAME_BITS-1:0]        frame_q, frame_d;
  logic                         in_comment_q, in_comment_d;
  logic                         has_data_q, has_data_d;
  logic [tlri_pkg::HeaderW-1:0] header_left_q, header_left_d;
  logic [MAX_COMMENT_CHARS-1:0] hit;
  logic                         cmt_match;
  logic                         is_eol;
  logic                         in_header;

  // comment byte match, one comparator per slot
  always_comb begin
    for (int k = 0; k < MAX_COMMENT_CHARS; k++) begin
      hit[k] = (tlri_pkg::CommentCountW'(k) < cfg_i.comment_count) &&
               (cfg_i.comment_chars[8*k +: 8] == byte_i);
    end
  end
  assign cmt_match = |hit;

  // saturating next offset
  assign offset_nxt = (offset_q == {OFFSET_BITS{1'b1}}) ? offset_q
                                                       : offset_q + 1'b1;
  assign in_header  = (header_left_q != '0);
  assign is_eol     = (byte_i == tlri_pkg::LfByte) || (byte_i == tlri_pkg::CrByte);

  // classify the staged byte; the state only moves when the byte steps on or a header count loads
  always_comb begin
    offset_d      = offset_nxt;
    frame_d       = frame_q;
    in_comment_d  = in_comment_q;
    has_data_d    = has_data_q;
    header_left_d = header_left_q;
    res_valid_o   = 1'b0;
    res_data_o    = 1'b0;
    res_header_o  = 1'b0;
    if (in_header) begin
      if (byte_i == tlri_pkg::LfByte) begin
        header_left_d = header_left_q - 1'b1;
        res_valid_o   = 1'b1;
        res_header_o  = 1'b1;
      end
    end else if (!in_comment_q && cmt_match) begin
      in_comment_d = 1'b1;
    end else if (is_eol) begin
      if (has_data_q && (frame_q != {FRAME_BITS{1'b1}})) begin
        frame_d = frame_q + 1'b1;
      end
      in_comment_d = 1'b0;
      has_data_d   = 1'b0;
      res_valid_o  = 1'b1;
      res_data_o   = has_data_q;
    end else if (!in_comment_q && !tlri_pkg::is_white(byte_i)) begin
      has_data_d = 1'b1;
    end
    // hold the state while no byte moves on
    if (!step_i) begin
      offset_d      = offset_q;
      frame_d       = frame_q;
      in_comment_d  = in_comment_q;
      has_data_d    = has_data_q;
      header_left_d = header_left_q;
      if (hdr_load_i.load && (offset_q == '0)) begin
        // header count only takes effect before the first byte
        header_left_d = hdr_load_i.value;
      end
    end
  end

  assign res_slot_o   = frame_d;
  assign res_offset_o = offset_nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q      <= '0;
      frame_q       <= '0;
      in_comment_q  <= 1'b0;
      has_data_q    <= 1'b0;
      header_left_q <= tlri_pkg::HeaderLinesReset;
    end else begin
      offset_q      <= offset_d;
      frame_q       <= frame_d;
      in_comment_q  <= in_comment_d;
      has_data_q    <= has_data_d;
      header_left_q <= header_left_d;
    end
  end

`ifndef SYNTHESIS
  a_offset_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |=> offset_q != '0)
    else $error("byte offset still zero after a byte");
  a_frame_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (frame_q == $past(frame_q) || frame_q == $past(frame_q) + 1'b1))
    else $error("row slot moved by more than one");
  a_header_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!step_i && !hdr_load_i.load) |=> $stable(header_left_q))
    else $error("header counter changed without a byte or load");
`endif

endmodule

// ===== design/text_line_row_indexer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_line_row_indexer_top
// Row index builder for a byte stream of a text file.
// ----------------------------------------------------------------------------
// Accepts one byte per clock and emits one transaction for every line end
// (LF or CR not taken as a comment byte, or only LF while header lines are
// skipped) with the row slot and the offset of the next line. Each byte
// passes an input register, classification against the comment set and a
// result register, at one byte per cycle; the input only stalls when a line
// end result meets a full, stalled result register. Configuration must be
// written while no transaction is in flight, not enforced by the block; a
// header line count takes effect only before the first byte after reset.
module text_line_row_indexer_top #(
  parameter int OFFSET_BITS       = tlri_pkg::OffsetBitsDefault,
  parameter int FRAME_BITS        = tlri_pkg::FrameBitsDefault,
  parameter int MAX_COMMENT_CHARS = tlri_pkg::MaxCommentCharsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tlri_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tlri_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [FRAME_BITS-1:0]         row_slot_o,
  output logic [OFFSET_BITS-1:0]        row_offset_o,
  output logic                          data_row_o,
  output logic                          header_row_o
);

  tlri_pkg::cfg_t      cfg;
  tlri_pkg::hdr_load_t hdr_load;

  logic                   s1_valid_q, s1_valid_d;
  logic [7:0]             s1_byte_q;
  logic                   s1_adv;
  logic                   in_take;
  logic                   res_valid;
  logic [FRAME_BITS-1:0]  res_slot;
  logic [OFFSET_BITS-1:0] res_offset;
  logic                   res_data;
  logic                   res_header;
  logic                   out_valid_q, out_valid_d;
  logic                   out_load;
  logic [FRAME_BITS-1:0]  row_slot_q;
  logic [OFFSET_BITS-1:0] row_offset_q;
  logic                   data_row_q;
  logic                   header_row_q;

  tlri_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .hdr_load_o  (hdr_load)
  );

  tlri_scan #(
    .OFFSET_BITS       (OFFSET_BITS),
    .FRAME_BITS        (FRAME_BITS),
    .MAX_COMMENT_CHARS (MAX_COMMENT_CHARS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .hdr_load_i   (hdr_load),
    .step_i       (s1_adv),
    .byte_i       (s1_byte_q),
    .res_valid_o  (res_valid),
    .res_slot_o   (res_slot),
    .res_offset_o (res_offset),
    .res_data_o   (res_data),
    .res_header_o (res_header)
  );

  // staged byte moves on unless its result finds the result register blocked
  assign s1_adv     = s1_valid_q && (!res_valid || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_load   = s1_adv && res_valid;

  // valid tracking for both stages
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= data_byte_i;
    end
    if (out_load) begin
      row_slot_q   <= res_slot;
      row_offset_q <= res_offset;
      data_row_q   <= res_data;
      header_row_q <= res_header;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign row_slot_o   = row_slot_q;
  assign row_offset_o = row_offset_q;
  assign data_row_o   = data_row_q;
  assign header_row_o = header_row_q;

`ifndef SYNTHESIS
  a_stall_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && res_valid && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");
  a_take_stages: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> s1_valid_q)
    else $error("accepted byte not staged");
  a_row_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(data_row_o && header_row_o))
    else $error("line marked both header and data");
`endif

endmodule

// ===== bench/text_line_row_indexer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_line_row_indexer_checker
// Watches the byte and row channels, predicts every row transaction from the
// accepted bytes and configuration writes, and compares field by field.
// ----------------------------------------------------------------------------
module text_line_row_indexer_checker #(
  parameter int OFFSET_BITS       = tlri_pkg::OffsetBitsDefault,
  parameter int FRAME_BITS        = tlri_pkg::FrameBitsDefault,
  parameter int MAX_COMMENT_CHARS = tlri_pkg::MaxCommentCharsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tlri_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tlri_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [FRAME_BITS-1:0]         row_slot_i,
  input  logic [OFFSET_BITS-1:0]        row_offset_i,
  input  logic                          data_row_i,
  input  logic                          header_row_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            rows_o,
  output int                            data_rows_o,
  output int                            header_rows_o
);

  localparam int ReportLimit = 10;
  localparam logic [7:0] SpaceByte = 8'h20;
  localparam logic [7:0] TabByte   = 8'h09;

  typedef struct packed {
    logic [FRAME_BITS-1:0]  slot;
    logic [OFFSET_BITS-1:0] offset;
    logic                   data;
    logic                   header;
  } row_entry_t;

  // configuration copy
  logic [tlri_pkg::CfgDataW-1:0]      cmt_chars;
  logic [tlri_pkg::CommentCountW-1:0] cmt_count;
  logic [tlri_pkg::HeaderW-1:0]       hdr_lines;

  // scanner state copy
  logic [OFFSET_BITS-1:0]       ofs;
  logic [FRAME_BITS-1:0]        slot;
  logic                         in_cmt;
  logic                         has_data;
  logic [tlri_pkg::HeaderW-1:0] hdr_left;

  row_entry_t rows_due[$];
  int mismatches = 0;
  int rows_seen = 0;
  int data_seen = 0;
  int header_seen = 0;

  // advance the scanner by one byte, returns 1 when a line end yields a row
  function automatic bit index_byte(input logic [7:0] b, output row_entry_t row);
    logic [OFFSET_BITS-1:0] nxt;
    bit hit;
    int lim;
    nxt = (ofs == {OFFSET_BITS{1'b1}}) ? ofs : ofs + 1'b1;
    ofs = nxt;
    row = '0;
    // header lines: only LF ends one, everything else is just counted
    if (hdr_left != 0) begin
      if (b != tlri_pkg::LfByte) return 1'b0;
      hdr_left = hdr_left - 1'b1;
      row.slot   = slot;
      row.offset = nxt;
      row.header = 1'b1;
      return 1'b1;
    end
    // first comment byte on a line wins, even over a line end
    lim = (cmt_count > MAX_COMMENT_CHARS) ? MAX_COMMENT_CHARS : int'(cmt_count);
    hit = 1'b0;
    for (int k = 0; k < MAX_COMMENT_CHARS; k++) begin
      if (k < lim && cmt_chars[8*k +: 8] == b) hit = 1'b1;
    end
    if (!in_cmt && hit) begin
      in_cmt = 1'b1;
      return 1'b0;
    end
    if (b == tlri_pkg::LfByte || b == tlri_pkg::CrByte) begin
      if (has_data && slot != {FRAME_BITS{1'b1}}) slot = slot + 1'b1;
      row.slot   = slot;
      row.offset = nxt;
      row.data   = has_data;
      has_data   = 1'b0;
      in_cmt     = 1'b0;
      return 1'b1;
    end
    if (!in_cmt && b != SpaceByte && !(b >= TabByte && b <= tlri_pkg::CrByte)) begin
      has_data = 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    row_entry_t want;
    if (!rst_ni) begin
      cmt_chars = tlri_pkg::CommentCharsReset;
      cmt_count = tlri_pkg::CommentCountReset;
      hdr_lines = tlri_pkg::HeaderLinesReset;
      ofs       = '0;
      slot      = '0;
      in_cmt    = 1'b0;
      has_data  = 1'b0;
      hdr_left  = tlri_pkg::HeaderLinesReset;
      rows_due.delete();
      pending_o <= 0;
    end else begin
      // register writes; header count loads only before the first byte
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tlri_pkg::RegCommentChars: cmt_chars = cfg_wdata_i;
          tlri_pkg::RegCommentCount:
            cmt_count = cfg_wdata_i[tlri_pkg::CommentCountW-1:0];
          tlri_pkg::RegHeaderLines: begin
            hdr_lines = cfg_wdata_i[tlri_pkg::HeaderW-1:0];
            if (ofs == '0) hdr_left = hdr_lines;
          end
          default: ;
        endcase
      end
      // byte transaction
      if (in_valid_i && !in_stall_i) begin
        if (index_byte(data_byte_i, want)) rows_due.push_back(want);
      end
      // row transaction
      if (out_valid_i && !out_stall_i) begin
        rows_seen++;
        if (data_row_i) data_seen++;
        if (header_row_i) header_seen++;
        if (rows_due.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("%t row transaction with nothing expected: slot %0d offset %0d",
                     $time, row_slot_i, row_offset_i);
        end else begin
          want = rows_due.pop_front();
          if (row_slot_i !== want.slot || row_offset_i !== want.offset ||
              data_row_i !== want.data || header_row_i !== want.header) begin
            mismatches++;
            if (mismatches <= ReportLimit)
              $display({"%t row mismatch: slot %0d/%0d offset %0d/%0d",
                        " data %0b/%0b header %0b/%0b (exp/act)"},
                       $time, want.slot, row_slot_i, want.offset, row_offset_i,
                       want.data, data_row_i, want.header, header_row_i);
          end
        end
      end
      pending_o <= rows_due.size();
    end
    fail_count_o  <= mismatches;
    rows_o        <= rows_seen;
    data_rows_o   <= data_seen;
    header_rows_o <= header_seen;
  end

endmodule

// ===== bench/text_line_row_indexer_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_line_row_indexer_top_test
// Regression for the text line row indexer.
// ----------------------------------------------------------------------------
// Streams a short hand-picked text with header lines, comments, white space
// and every kind of line end, then random text lines under several comment
// settings, with random gaps on both channels and one long output hold that
// backs the block up. The checker predicts and compares every row.
module text_line_row_indexer_top_test;

  localparam int CycleLimit   = 1_000_000;
  localparam int PhaseCount   = 8;
  localparam int PhaseItems   = 244;
  localparam int LongHold     = 400;
  localparam int SettleCycles = 4;
  localparam int DrainCycles  = 8;
  localparam logic [7:0] TextLo = 8'h21;
  localparam logic [7:0] TextHi = 8'h7E;

  // hand-picked opening: two header lines (a CR inside one), CR LF pair,
  // comment line, white-space line, high and zero bytes, ';' and trailing '#'
  localparam logic [25*8-1:0] OpeningText = {
    8'h68, tlri_pkg::CrByte, 8'h78, tlri_pkg::LfByte, tlri_pkg::LfByte,
    8'h31, 8'h20, 8'h32, tlri_pkg::CrByte, tlri_pkg::LfByte,
    8'h23, 8'h63, tlri_pkg::LfByte,
    8'h0B, 8'h09, tlri_pkg::LfByte,
    8'h80, 8'hFF, 8'h00, tlri_pkg::LfByte,
    8'h3B, tlri_pkg::CrByte,
    8'h61, 8'h23, tlri_pkg::LfByte
  };

  logic                                   clk_i;
  logic                                   rst_ni;
  logic                                   cfg_we_i;
  logic [tlri_pkg::CfgIdxW-1:0]           cfg_idx_i;
  logic [tlri_pkg::CfgDataW-1:0]          cfg_wdata_i;
  logic                                   in_valid_i;
  logic                                   in_stall_o;
  logic [7:0]                             data_byte_i;
  logic                                   out_valid_o;
  logic                                   out_stall_i;
  logic [tlri_pkg::FrameBitsDefault-1:0]  row_slot_o;
  logic [tlri_pkg::OffsetBitsDefault-1:0] row_offset_o;
  logic                                   data_row_o;
  logic                                   header_row_o;

  int fails;
  int pending;
  int rows;
  int data_rows;
  int header_rows;

  int  cycle_count = 0;
  int  bytes_sent = 0;
  bit  tx_quiet = 1'b0;
  bit  rx_quiet = 1'b0;
  bit  rx_hold_req = 1'b0;
  logic [tlri_pkg::CfgDataW-1:0]      cur_chars = tlri_pkg::CommentCharsReset;
  logic [tlri_pkg::CommentCountW-1:0] cur_count = tlri_pkg::CommentCountReset;

  text_line_row_indexer_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .row_slot_o   (row_slot_o),
    .row_offset_o (row_offset_o),
    .data_row_o   (data_row_o),
    .header_row_o (header_row_o)
  );

  text_line_row_indexer_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .row_slot_i    (row_slot_o),
    .row_offset_i  (row_offset_o),
    .data_row_i    (data_row_o),
    .header_row_i  (header_row_o),
    .fail_count_o  (fails),
    .pending_o     (pending),
    .rows_o        (rows),
    .data_rows_o   (data_rows),
    .header_rows_o (header_rows)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("text_line_row_indexer_top regression: fail");
      $finish;
    end
  end

  // printable byte, sometimes a space
  function automatic logic [7:0] pick_text();
    if ($urandom_range(0, 3) == 0) return 8'h20;
    return 8'($urandom_range(TextLo, TextHi));
  endfunction

  // one of the comment bytes now in use, or text when there are none
  function automatic logic [7:0] pick_comment();
    int lim;
    lim = (cur_count > tlri_pkg::MaxCommentCharsDefault) ?
          tlri_pkg::MaxCommentCharsDefault : int'(cur_count);
    if (lim == 0) return pick_text();
    return cur_chars[8*$urandom_range(0, lim-1) +: 8];
  endfunction

  // register write, only while the block is idle
  task automatic write_reg(input logic [tlri_pkg::CfgIdxW-1:0]  idx,
                           input logic [tlri_pkg::CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tlri_pkg::RegCommentChars: cur_chars = val;
      tlri_pkg::RegCommentCount: cur_count = val[tlri_pkg::CommentCountW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // byte transaction with a random lead-in gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
  endtask

  // drain all expected rows, then let the pipeline settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // row receiver with random holds and one long hold on request
  initial begin : receiver
    int hold;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold = LongHold;
      end else begin
        hold = rx_quiet ? 0 : $urandom_range(0, 15);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int kind;
    int len;
    int budget_end;
    logic [tlri_pkg::CfgDataW-1:0] val;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    data_byte_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // both header writes land before the first byte, so the last one loads
    write_reg(tlri_pkg::RegHeaderLines, 64'hFFFF);
    write_reg(tlri_pkg::RegHeaderLines, 64'd2);
    for (int i = 24; i >= 0; i--) send_byte(OpeningText[8*i +: 8]);

    for (int p = 0; p < PhaseCount; p++) begin
      if (p > 0) begin
        wait_idle();
        case (p)
          1: begin
            // zero bytes as comments
            write_reg(tlri_pkg::RegCommentChars, '0);
            write_reg(tlri_pkg::RegCommentCount, 64'd8);
            write_reg(tlri_pkg::RegHeaderLines, 64'd0);
          end
          2: begin
            // all 0xFF, count above the maximum
            write_reg(tlri_pkg::RegCommentChars, '1);
            write_reg(tlri_pkg::RegCommentCount, 64'd15);
            write_reg(tlri_pkg::RegHeaderLines, 64'hFFFF);
          end
          3: begin
            // line end bytes as comment bytes
            val = {$urandom(), $urandom()};
            val[15:0] = {tlri_pkg::CrByte, tlri_pkg::LfByte};
            write_reg(tlri_pkg::RegCommentChars, val);
            write_reg(tlri_pkg::RegCommentCount, 64'd3);
          end
          4: begin
            // no comment bytes in use
            write_reg(tlri_pkg::RegCommentChars, {$urandom(), $urandom()});
            write_reg(tlri_pkg::RegCommentCount, 64'd0);
          end
          5: begin
            write_reg(tlri_pkg::RegCommentChars, {$urandom(), $urandom()});
            write_reg(tlri_pkg::RegCommentCount,
                      tlri_pkg::CfgDataW'($urandom_range(1, 8)));
            write_reg(tlri_pkg::RegHeaderLines,
                      tlri_pkg::CfgDataW'($urandom_range(0, 65535)));
          end
          6: begin
            // printable comment bytes, so text lines hit them often
            for (int k = 0; k < 8; k++) val[8*k +: 8] = 8'($urandom_range(TextLo, TextHi));
            write_reg(tlri_pkg::RegCommentChars, val);
            write_reg(tlri_pkg::RegCommentCount, 64'd8);
          end
          default: begin
            write_reg(tlri_pkg::RegCommentChars, tlri_pkg::CommentCharsReset);
            write_reg(tlri_pkg::RegCommentCount, 64'd1);
            write_reg(tlri_pkg::RegHeaderLines, 64'd1);
          end
        endcase
      end
      // long output hold while bytes keep coming
      if (p == 2) rx_hold_req = 1'b1;

      budget_end = bytes_sent + PhaseItems;
      while (bytes_sent < budget_end) begin
        kind = $urandom_range(0, 10);
        len  = $urandom_range(1, 12);
        case (kind)
          0: ;
          1: repeat (len) begin
            case ($urandom_range(0, 3))
              0: send_byte(8'h09);
              1: send_byte(8'h0B);
              2: send_byte(8'h0C);
              default: send_byte(8'h20);
            endcase
          end
          2, 3, 4: repeat (len) send_byte(pick_text());
          5: begin
            repeat ($urandom_range(0, 2)) send_byte(8'h20);
            send_byte(pick_comment());
            repeat (len) send_byte(pick_text());
          end
          6: begin
            repeat (len) send_byte(pick_text());
            send_byte(pick_comment());
            repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 255)));
          end
          7: repeat (len) send_byte(8'($urandom_range(0, 255)));
          8: repeat (len) send_byte(8'($urandom_range(128, 255)));
          default: repeat (len) send_byte(pick_text());
        endcase
        // most lines end; the last kind runs on into the next line
        if (kind != 10) begin
          case ($urandom_range(0, 2))
            0: send_byte(tlri_pkg::LfByte);
            1: send_byte(tlri_pkg::CrByte);
            default: begin
              send_byte(tlri_pkg::CrByte);
              send_byte(tlri_pkg::LfByte);
            end
          endcase
        end
      end
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d bytes over %0d comment and header settings", bytes_sent, PhaseCount);
    $display("checked %0d line ends: %0d data rows, %0d skipped header lines",
             rows, data_rows, header_rows);
    if (fails == 0) begin
      $display("text_line_row_indexer_top regression: pass");
    end else begin
      $display("text_line_row_indexer_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/tlri_pkg.sv
design/tlri_cfg_regs.sv
design/tlri_scan.sv
design/text_line_row_indexer_top.sv
bench/text_line_row_indexer_checker.sv
bench/text_line_row_indexer_top_test.sv
